/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the range set unit.
// Depends on nothing; each macro takes a label, clock, active-low reset and terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("range set check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("range set check failed");

`endif

/* rtl/sirs_pkg.sv */
// Shared types and constants of the sorted id range set unit.
// Depends on nothing; used by the engine and the top level.
package sirs_pkg;

  localparam int MaxRanges = 16;
  localparam int IdxW      = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;
  localparam int CntW      = $clog2(MaxRanges + 1);
  localparam int AddrW     = IdxW + 1;
  localparam int RamDepth  = 2 ** AddrW;

  localparam logic [31:0] IdTop = 32'hFFFF_FFFF;

  localparam logic [1:0] ActAdd    = 2'd0;
  localparam logic [1:0] ActRemove = 2'd1;
  localparam logic [1:0] ActRead   = 2'd2;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] size;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] entry_first;
    logic [31:0] entry_size;
    logic [4:0]  used;
    logic [31:0] covered;
    logic        full;
  } res_t;

endpackage

/* rtl/sirs_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module sirs_ram #(
  parameter int Width = 64,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sirs_engine.sv */
// Sequencer of the range set: answers reads from the live bank of the table RAM and streams
// that bank through the add or remove rules into the other bank. Depends on sirs_pkg.
module sirs_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic [1:0]                action_i,
  input  logic [31:0]               first_id_i,
  input  logic [31:0]               id_count_i,
  input  logic [3:0]                read_index_i,
  output logic                      ram_we_o,
  output logic [sirs_pkg::AddrW-1:0] ram_waddr_o,
  output sirs_pkg::entry_t          ram_wdata_o,
  output logic [sirs_pkg::AddrW-1:0] ram_raddr_o,
  input  sirs_pkg::entry_t          ram_rdata_i,
  output sirs_pkg::res_t            res_o,
  output logic                      busy_o
);
  import sirs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RSP, S_RD, S_PROC, S_WR2, S_FIN, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    M_SEEK, M_MERGE, M_COPY, M_CUT, M_SKIP
  } mode_e;

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic             bank_q, bank_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [31:0]      total_q, total_d;
  logic             add_q, add_d;
  logic [31:0]      start_q, start_d;
  logic [32:0]      end_q, end_d;
  logic [31:0]      pf_q, pf_d;
  logic [32:0]      top_q, top_d;
  logic [CntW-1:0]  i_q, i_d;
  logic [CntW-1:0]  oi_q, oi_d;
  logic [32:0]      sum_q, sum_d;
  entry_t           w2_q, w2_d;
  logic             rd_ok_q, rd_ok_d;
  logic [31:0]      res_first_q, res_first_d;
  logic [31:0]      res_size_q, res_size_d;
  logic             full_q, full_d;

  logic             w_v;
  entry_t           w_e;
  logic [32:0]      cs33, ce33, st33;
  logic [31:0]      mn;
  logic [31:0]      room, len_c;
  logic             split_full;

  function automatic logic [32:0] sat_add(logic [32:0] a, logic [31:0] b);
    logic [32:0] s;
    s = a + {1'b0, b};
    return s[32] ? 33'h1_0000_0000 : s;
  endfunction

  assign cs33  = {1'b0, ram_rdata_i.first};
  assign ce33  = cs33 + {1'b0, ram_rdata_i.size};
  assign st33  = {1'b0, start_q};
  assign mn    = (start_q < ram_rdata_i.first) ? start_q : ram_rdata_i.first;
  assign room  = IdTop - first_id_i;
  assign len_c = (id_count_i > room) ? room : id_count_i;
  // A split needs one more entry than the table holds at this point.
  assign split_full = ({1'b0, oi_q} + {1'b0, count_q} - {1'b0, i_q})
                      >= (CntW+1)'(MaxRanges);

  assign ram_raddr_o = (state_q == S_IDLE) ? {bank_q, IdxW'(read_index_i)}
                                           : {bank_q, i_q[IdxW-1:0]};
  assign ram_waddr_o = {~bank_q, oi_q[IdxW-1:0]};

  always_comb begin
    logic [32:0] fsum;
    fsum        = sum_q;
    state_d     = state_q;
    mode_d      = mode_q;
    bank_d      = bank_q;
    count_d     = count_q;
    total_d     = total_q;
    add_d       = add_q;
    start_d     = start_q;
    end_d       = end_q;
    pf_d        = pf_q;
    top_d       = top_q;
    i_d         = i_q;
    oi_d        = oi_q;
    sum_d       = sum_q;
    w2_d        = w2_q;
    rd_ok_d     = rd_ok_q;
    res_first_d = res_first_q;
    res_size_d  = res_size_q;
    full_d      = full_q;
    w_v         = 1'b0;
    w_e         = ram_rdata_i;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          res_first_d = '0;
          res_size_d  = '0;
          full_d      = 1'b0;
          start_d     = first_id_i;
          add_d       = (action_i == ActAdd);
          i_d         = '0;
          oi_d        = '0;
          sum_d       = '0;
          unique case (action_i)
            ActAdd: begin
              if (id_count_i == 32'd0 || first_id_i == IdTop) begin
                state_d = S_DONE;
              end else begin
                end_d   = {1'b0, first_id_i} + {1'b0, len_c};
                mode_d  = M_SEEK;
                state_d = S_RD;
              end
            end
            ActRemove: begin
              if (id_count_i == 32'd0) begin
                state_d = S_DONE;
              end else begin
                end_d   = {1'b0, first_id_i} + {1'b0, id_count_i};
                mode_d  = M_CUT;
                state_d = S_RD;
              end
            end
            ActRead: begin
              rd_ok_d = 32'(read_index_i) < 32'(count_q);
              state_d = S_RSP;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_RSP: begin
        if (rd_ok_q) begin
          res_first_d = ram_rdata_i.first;
          res_size_d  = ram_rdata_i.size;
        end
        state_d = S_DONE;
      end
      S_RD: begin
        state_d = (i_q == count_q) ? S_FIN : S_PROC;
      end
      S_PROC: begin
        i_d     = i_q + CntW'(1);
        state_d = S_RD;
        if (add_q) begin
          unique case (mode_q)
            M_SEEK: begin
              if (end_q < cs33) begin
                if (count_q == CntW'(MaxRanges)) begin
                  full_d  = 1'b1;
                  state_d = S_DONE;
                end else begin
                  w_v     = 1'b1;
                  w_e     = '{first: start_q, size: 32'(end_q - st33)};
                  w2_d    = ram_rdata_i;
                  mode_d  = M_COPY;
                  state_d = S_WR2;
                end
              end else if (st33 > ce33) begin
                w_v = 1'b1;
              end else if (end_q <= ce33) begin
                w_v    = 1'b1;
                w_e    = '{first: mn, size: 32'(ce33 - {1'b0, mn})};
                mode_d = M_COPY;
              end else begin
                pf_d   = mn;
                top_d  = end_q;
                mode_d = M_MERGE;
              end
            end
            M_MERGE: begin
              if (cs33 < top_q) begin
                if (ce33 > top_q) begin
                  top_d = ce33;
                end
              end else begin
                w_v     = 1'b1;
                w_e     = '{first: pf_q, size: 32'(top_q - {1'b0, pf_q})};
                w2_d    = ram_rdata_i;
                mode_d  = M_COPY;
                state_d = S_WR2;
              end
            end
            default: w_v = 1'b1;
          endcase
        end else begin
          if (mode_q == M_SKIP) begin
            w_v    = 1'b1;
            mode_d = M_CUT;
          end else if (end_q > cs33 && st33 < ce33) begin
            if (st33 > cs33 && end_q < ce33) begin
              if (split_full) begin
                // No room to split: keep this entry and pass the next one untouched.
                w_v    = 1'b1;
                full_d = 1'b1;
                mode_d = M_SKIP;
              end else begin
                w_v     = 1'b1;
                w_e     = '{first: ram_rdata_i.first, size: start_q - ram_rdata_i.first};
                w2_d    = '{first: end_q[31:0], size: 32'(ce33 - end_q)};
                state_d = S_WR2;
              end
            end else if (st33 > cs33) begin
              w_v = 1'b1;
              w_e = '{first: ram_rdata_i.first, size: start_q - ram_rdata_i.first};
            end else if (end_q < ce33) begin
              w_v = 1'b1;
              w_e = '{first: end_q[31:0], size: 32'(ce33 - end_q)};
            end
          end else begin
            w_v = 1'b1;
          end
        end
      end
      S_WR2: begin
        w_v     = 1'b1;
        w_e     = w2_q;
        state_d = S_RD;
      end
      S_FIN: begin
        state_d = S_DONE;
        if (add_q && mode_q == M_SEEK && count_q == CntW'(MaxRanges)) begin
          full_d = 1'b1;
        end else begin
          if (add_q && mode_q == M_SEEK) begin
            w_v = 1'b1;
            w_e = '{first: start_q, size: 32'(end_q - st33)};
          end else if (add_q && mode_q == M_MERGE) begin
            w_v = 1'b1;
            w_e = '{first: pf_q, size: 32'(top_q - {1'b0, pf_q})};
          end
          if (w_v) begin
            fsum = sat_add(sum_q, w_e.size);
          end
          bank_d  = ~bank_q;
          count_d = w_v ? oi_q + CntW'(1) : oi_q;
          total_d = fsum[32] ? IdTop : fsum[31:0];
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    if (w_v) begin
      oi_d  = oi_q + CntW'(1);
      sum_d = sat_add(sum_q, w_e.size);
    end
  end

  assign ram_we_o    = w_v;
  assign ram_wdata_o = w_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_SEEK;
      bank_q  <= 1'b0;
      count_q <= '0;
      total_q <= '0;
      i_q     <= '0;
      oi_q    <= '0;
      full_q  <= 1'b0;
      add_q   <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      bank_q  <= bank_d;
      count_q <= count_d;
      total_q <= total_d;
      i_q     <= i_d;
      oi_q    <= oi_d;
      full_q  <= full_d;
      add_q   <= add_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    end_q       <= end_d;
    pf_q        <= pf_d;
    top_q       <= top_d;
    sum_q       <= sum_d;
    w2_q        <= w2_d;
    res_first_q <= res_first_d;
    res_size_q  <= res_size_d;
  end

  assign res_o.valid       = (state_q == S_DONE);
  assign res_o.entry_first = res_first_q;
  assign res_o.entry_size  = res_size_q;
  assign res_o.used        = 5'(count_q);
  assign res_o.covered     = total_q;
  assign res_o.full        = full_q;
  assign busy_o            = (state_q != S_IDLE);

endmodule

/* rtl/sorted_id_range_set_unit.sv */
// Top level of the sorted id range set unit: table RAM, sequencer and result register.
// Depends on sirs_pkg, sirs_ram and sirs_engine.
//
// Usage. An item (action, first id, id count, read index) is taken at a rising
// edge where start is high and busy is low. Action add merges a range into the
// table, remove cuts a range out, read returns one entry; any other code only
// reports the counters. Every item gives exactly one result, shown for a single
// cycle with result_valid_o high; the receiver cannot hold it off, so it must
// take it in that cycle. Busy drops in the same cycle the result is shown, and
// the next item may be started then.
// Sequence. A read item goes through a response state and the done state before its
// result is registered. An add or remove streams every stored entry once through the
// table RAM, whose registered read port returns one entry per cycle. Each entry takes
// a read and a processing state, the single inserted, split or merged entry an item
// may add its own write state, and the pass ends in the finish and done states.
// The table is double banked in one RAM: the rewritten table goes to the spare
// bank and the banks swap when the pass ends, so an add that finds the table
// full simply leaves the live bank as it was.
// Reset empties the table at once (entry count and total go to zero); the RAM
// itself is not cleared, as entries past the count are never read.
module sorted_id_range_set_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [31:0] first_id_i,
  input  logic [31:0] id_count_i,
  input  logic [3:0]  read_index_i,
  output logic        result_valid_o,
  output logic [31:0] entry_first_o,
  output logic [31:0] entry_size_o,
  output logic [4:0]  used_entries_o,
  output logic [31:0] covered_ids_o,
  output logic        table_full_o
);
  import sirs_pkg::*;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [AddrW-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  res_t             res;

  // Result register: the strobe is reset, the payload only loads with it.
  logic             valid_q;
  res_t             res_q;

  sirs_ram #(
    .Width ($bits(entry_t)),
    .Depth (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sirs_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .action_i     (action_i),
    .first_id_i   (first_id_i),
    .id_count_i   (id_count_i),
    .read_index_i (read_index_i),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .res_o        (res),
    .busy_o       (busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      res_q <= res;
    end
  end

  assign result_valid_o = valid_q;
  assign entry_first_o  = res_q.entry_first;
  assign entry_size_o   = res_q.entry_size;
  assign used_entries_o = res_q.used;
  assign covered_ids_o  = res_q.covered;
  assign table_full_o   = res_q.full;

endmodule

/* rtl/sirs_chk.sv */
// Port-level checker for the range set unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sirs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [31:0] entry_first_o,
  input logic [31:0] entry_size_o,
  input logic        table_full_o
);

  logic full_res;
  logic entry_zero;

  assign full_res   = result_valid_o && table_full_o;
  assign entry_zero = (entry_first_o == 32'd0) && (entry_size_o == 32'd0);

  `SIRS_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, start && !busy, busy)
  `SIRS_ASSERT_IMP(a_result_not_busy, clk_i, rst_ni, result_valid_o, !busy)
  `SIRS_ASSERT_IMP(a_busy_ends_in_result, clk_i, rst_ni, $fell(busy), result_valid_o)
  `SIRS_ASSERT_IMP(a_full_no_entry, clk_i, rst_ni, full_res, entry_zero)

endmodule

bind sorted_id_range_set_unit sirs_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .entry_first_o  (entry_first_o),
  .entry_size_o   (entry_size_o),
  .table_full_o   (table_full_o)
);
